[src/tfidf_pkg.sv]
// ----------------------------------------------------------------------------
// tfidf_pkg: shared types and constants for tf-idf row weighting
// Field widths, controller states and command/status structs.
// ----------------------------------------------------------------------------
package tfidf_pkg;

    localparam int CountW  = 16;
    localparam int WeightW = 24;
    localparam int SmoothW = 16;
    localparam int SumW    = 22;
    localparam int NumW    = 25;  // smoothing + count*256
    localparam int DenW    = 31;  // smoothing*64 + sum*256
    localparam int ProdW   = NumW + WeightW;
    localparam int StatW   = 2;

    localparam logic [StatW-1:0] StatOk    = 2'd0;
    localparam logic [StatW-1:0] StatZero  = 2'd1;
    localparam logic [StatW-1:0] StatTrunc = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic store;      // buffer accepted item
        logic start_read; // read entry at emit index
        logic start_mul;  // form numerator*weight, start division
        logic emit;       // result handed to output reg
        logic row_done;   // clear row state
    } cmd_t;

    typedef struct packed {
        logic closes_row; // accepted item is last
        logic div_done;
        logic last_elem;  // emit index is final term
        logic row_empty;  // no terms buffered at close
    } stat_t;

endpackage

[src/tfidf_if.sv]
// ----------------------------------------------------------------------------
// tfidf_if: valid/ready channel carrying a generic payload
// ----------------------------------------------------------------------------
interface tfidf_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/tfidf_ctrl.sv]
// ----------------------------------------------------------------------------
// tfidf_ctrl: row controller
// Loads terms, then steps read, multiply, divide and emit per term.
// ----------------------------------------------------------------------------
module tfidf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_free,
    input  tfidf_pkg::stat_t  stat,
    output logic              in_ready,
    output tfidf_pkg::cmd_t   cmd
);
    tfidf_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tfidf_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tfidf_pkg::ST_LOAD:
            begin
                if (in_fire && stat.closes_row)
                begin
                    state_next = tfidf_pkg::ST_READ;
                end
            end
            tfidf_pkg::ST_READ:
            begin
                // empty row closes without results
                if (stat.row_empty)
                begin
                    state_next = tfidf_pkg::ST_LOAD;
                end
                else
                begin
                    state_next = tfidf_pkg::ST_MUL;
                end
            end
            tfidf_pkg::ST_MUL: state_next = tfidf_pkg::ST_DIV;
            tfidf_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = tfidf_pkg::ST_OUT;
                end
            end
            tfidf_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = stat.last_elem ? tfidf_pkg::ST_LOAD
                                                : tfidf_pkg::ST_READ;
                end
            end
            default: state_next = tfidf_pkg::ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            tfidf_pkg::ST_LOAD:
            begin
                in_ready  = 1'b1;
                cmd.store = in_fire;
            end
            tfidf_pkg::ST_READ:
            begin
                cmd.start_read = 1'b1;
                cmd.row_done   = stat.row_empty;
            end
            tfidf_pkg::ST_MUL: cmd.start_mul = 1'b1;
            tfidf_pkg::ST_DIV: cmd = '0;
            tfidf_pkg::ST_OUT:
            begin
                cmd.emit     = out_free;
                cmd.row_done = out_free && stat.last_elem;
            end
            default: cmd = '0;
        endcase
    end
endmodule

[src/tfidf_dp.sv]
// ----------------------------------------------------------------------------
// tfidf_dp: row datapath
// Term buffers, sums, denominator, multiplier and restoring divider.
// ----------------------------------------------------------------------------
module tfidf_dp #(
    parameter int MAX_TERMS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tfidf_pkg::cmd_t                    cmd,
    input  logic [tfidf_pkg::SmoothW-1:0]      smoothing,
    input  logic [tfidf_pkg::CountW-1:0]       term_count,
    input  logic [tfidf_pkg::WeightW-1:0]      term_weight,
    input  logic                               last_term,
    output tfidf_pkg::stat_t                   stat,
    output logic [tfidf_pkg::WeightW-1:0]      value,
    output logic                               last_elem,
    output logic [tfidf_pkg::StatW-1:0]        status
);
    localparam int IdxW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CntW  = $clog2(MAX_TERMS + 1);
    localparam int ProdW = tfidf_pkg::ProdW;
    localparam int DenW  = tfidf_pkg::DenW;
    localparam int StepW = $clog2(ProdW + 1);

    logic [tfidf_pkg::CountW-1:0]  count_mem [MAX_TERMS];
    logic [tfidf_pkg::WeightW-1:0] weight_mem [MAX_TERMS];
    logic [tfidf_pkg::CountW-1:0]  rd_count_reg;
    logic [tfidf_pkg::WeightW-1:0] rd_weight_reg;

    logic [tfidf_pkg::SumW-1:0] sum_reg;
    logic [CntW-1:0]            terms_reg;
    logic                       ovf_reg;
    logic [CntW-1:0]            idx_reg;
    logic [DenW-1:0]            den_reg;
    logic [ProdW-1:0]           quo_reg;
    logic [DenW:0]              rem_reg;
    logic [StepW-1:0]           step_reg;
    logic                       div_busy_reg;

    logic full;
    logic [DenW:0] trial;
    logic [tfidf_pkg::NumW-1:0] num;
    logic [ProdW-1:0] prod;

    assign full = (terms_reg == CntW'(MAX_TERMS));

    always_ff @(posedge clk)
    begin
        if (cmd.store && !full)
        begin
            count_mem[terms_reg[IdxW-1:0]]  <= term_count;
            weight_mem[terms_reg[IdxW-1:0]] <= term_weight;
        end
        if (cmd.start_read)
        begin
            rd_count_reg  <= count_mem[idx_reg[IdxW-1:0]];
            rd_weight_reg <= weight_mem[idx_reg[IdxW-1:0]];
        end
    end

    // 24x25 product of numerator and idf
    assign num  = tfidf_pkg::NumW'(smoothing) + {1'b0, rd_count_reg, 8'd0};
    assign prod = ProdW'(num) * ProdW'(rd_weight_reg);
    assign trial = {rem_reg[DenW-1:0], quo_reg[ProdW-1]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            terms_reg    <= '0;
            ovf_reg      <= 1'b0;
            idx_reg      <= '0;
            div_busy_reg <= 1'b0;
            step_reg     <= '0;
        end
        else
        begin
            if (cmd.store)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    sum_reg   <= sum_reg + tfidf_pkg::SumW'(term_count);
                    terms_reg <= terms_reg + 1'b1;
                end
                if (last_term)
                begin
                    // denominator sees this item if it was kept
                    den_reg <= DenW'(smoothing) * DenW'(full ? terms_reg
                                                             : terms_reg + 1'b1)
                             + DenW'({(full ? sum_reg
                                            : sum_reg + tfidf_pkg::SumW'(term_count)),
                                      8'd0});
                end
            end
            if (cmd.start_mul)
            begin
                quo_reg      <= prod;
                rem_reg      <= '0;
                step_reg     <= StepW'(ProdW);
                div_busy_reg <= (den_reg != '0);
            end
            else if (div_busy_reg)
            begin
                if (!trial[DenW])
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[ProdW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[DenW-1:0], quo_reg[ProdW-1]};
                    quo_reg <= {quo_reg[ProdW-2:0], 1'b0};
                end
                step_reg <= step_reg - 1'b1;
                if (step_reg == StepW'(1))
                begin
                    div_busy_reg <= 1'b0;
                end
            end
            if (cmd.emit)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.row_done)
            begin
                sum_reg   <= '0;
                terms_reg <= '0;
                ovf_reg   <= 1'b0;
                idx_reg   <= '0;
            end
        end
    end

    assign stat.closes_row = last_term;
    assign stat.div_done   = !div_busy_reg && !cmd.start_mul;
    assign stat.last_elem  = (idx_reg + 1'b1 == terms_reg);
    assign stat.row_empty  = (terms_reg == '0);

    // quotient cannot pass idf, still clamp
    assign value = (den_reg == '0) ? '0
                 : (|quo_reg[ProdW-1:tfidf_pkg::WeightW]) ? '1
                 : quo_reg[tfidf_pkg::WeightW-1:0];
    assign last_elem = stat.last_elem;
    assign status = (den_reg == '0) ? tfidf_pkg::StatZero
                  : ovf_reg ? tfidf_pkg::StatTrunc : tfidf_pkg::StatOk;
endmodule

[src/tfidf_row_weighting.sv]
// Loading: a row of n terms loads one item per cycle; after the last item
// each result is read, multiplied, divided by the bit-serial divider and
// emitted (the divide is skipped when the denominator is zero).
// Results are computed one at a time; the next starts after the last is emitted.
// Input is held off while a row is being emitted.
// Reset: asynchronous active-low rst_n clears control, sums and smoothing;
// term buffers are not cleared.
// ----------------------------------------------------------------------------
// tfidf_row_weighting: smoothed tf-idf weighting of one document row
// Buffers a row of terms, then emits each term's weighted idf in order.
// ----------------------------------------------------------------------------
module tfidf_row_weighting #(
    parameter int MAX_TERMS = 64
) (
    input  logic clk,
    input  logic rst_n,
    tfidf_if.sink   cfg,
    tfidf_if.sink   in_ch,
    tfidf_if.source out_ch
);
    logic [tfidf_pkg::SmoothW-1:0] smooth_reg;
    tfidf_pkg::cmd_t  cmd;
    tfidf_pkg::stat_t stat;
    logic in_ready, in_fire, out_free;
    logic out_valid_reg;
    logic [tfidf_pkg::WeightW-1:0] val;
    logic [tfidf_pkg::WeightW-1:0] val_reg;
    logic lst, lst_reg;
    logic [tfidf_pkg::StatW-1:0] sts, sts_reg;

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= '0;
        end
        else if (cfg.valid)
        begin
            smooth_reg <= cfg.payload;
        end
    end

    assign in_ch.ready = in_ready;
    assign in_fire = in_ch.valid && in_ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    tfidf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
        .stat(stat), .in_ready(in_ready), .cmd(cmd)
    );

    tfidf_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .smoothing(smooth_reg),
        .term_count(in_ch.payload.term_count),
        .term_weight(in_ch.payload.term_weight),
        .last_term(in_ch.payload.last_term),
        .stat(stat), .value(val), .last_elem(lst), .status(sts)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            val_reg <= val;
            lst_reg <= lst;
            sts_reg <= sts;
        end
    end

    assign out_ch.valid                  = out_valid_reg;
    assign out_ch.payload.weighted_value = val_reg;
    assign out_ch.payload.last_result    = lst_reg;
    assign out_ch.payload.row_status     = sts_reg;

`ifndef ASSERT_OFF
    a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !cmd.emit)
        else $error("item taken while emitting");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("emit into full output register");
`endif
endmodule

[tb/tfidf_row_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfidf_row_checker: scoreboard for tf-idf row weighting
// Watches the config, term and result channels and predicts every weighted
// value of a row from its buffered terms. Compares results in order.
// ----------------------------------------------------------------------------
module tfidf_row_checker #(
    parameter int MAX_TERMS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [40:0] in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [26:0] out_data,
    output int          pending,
    output int          failures
);
    typedef struct packed {
        logic [15:0] term_count;
        logic [23:0] term_weight;
        logic        last_term;
    } term_t;

    typedef struct packed {
        logic [23:0] weighted_value;
        logic        last_result;
        logic [1:0]  row_status;
    } weighted_t;

    logic [15:0] smoothing;
    logic [15:0] row_counts [MAX_TERMS];
    logic [23:0] row_weights [MAX_TERMS];
    logic [21:0] row_sum;
    int          row_len;
    logic        row_dropped;
    weighted_t   expected_weights [$];

    assign pending = expected_weights.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        failures++;
    endtask

    // close the row: weight every buffered term
    task automatic weigh_row();
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] val;
        logic [1:0]  status;
        weighted_t   r;
        den = 64'(smoothing) * 64'(row_len) + (64'(row_sum) << 8);
        status = (den == 0) ? tfidf_pkg::StatZero
               : (row_dropped ? tfidf_pkg::StatTrunc : tfidf_pkg::StatOk);
        for (int k = 0; k < row_len; k++)
        begin
            val = 0;
            if (den != 0)
            begin
                num = 64'(smoothing) + (64'(row_counts[k]) << 8);
                val = (num * 64'(row_weights[k])) / den;
                if (val > 64'hFFFFFF)
                    val = 64'hFFFFFF;
            end
            r.weighted_value = val[23:0];
            r.last_result = (k + 1 == row_len);
            r.row_status = status;
            expected_weights.push_back(r);
        end
        row_sum = 0;
        row_len = 0;
        row_dropped = 0;
    endtask

    initial
    begin
        failures = 0;
        smoothing = 0;
        row_sum = 0;
        row_len = 0;
        row_dropped = 0;
    end

    always @(posedge clk)
    begin
        term_t     t;
        weighted_t got;
        weighted_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                smoothing = cfg_data;
            if (in_valid && in_ready)
            begin
                t = in_data;
                if (row_len < MAX_TERMS)
                begin
                    row_counts[row_len] = t.term_count;
                    row_weights[row_len] = t.term_weight;
                    row_sum = row_sum + 22'(t.term_count);
                    row_len++;
                end
                else
                    row_dropped = 1;
                if (t.last_term)
                    weigh_row();
            end
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (expected_weights.size() == 0)
                    report("unexpected item", 32'(got), 0);
                else
                begin
                    want = expected_weights.pop_front();
                    if (got.weighted_value !== want.weighted_value)
                        report("weighted_value", 32'(got.weighted_value),
                               32'(want.weighted_value));
                    if (got.last_result !== want.last_result)
                        report("last_result", 32'(got.last_result), 32'(want.last_result));
                    if (got.row_status !== want.row_status)
                        report("row_status", 32'(got.row_status), 32'(want.row_status));
                end
            end
        end
    end
endmodule

[tb/tfidf_row_weighting_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfidf_row_weighting_tb: stimulus and verdict for tf-idf row weighting
// Sends directed and random document rows under several smoothing settings,
// with random idling, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tfidf_row_weighting_tb;

    localparam int MaxTerms   = 64;
    localparam int CycleLimit = 2000000;
    localparam int SettleWait = 120;

    typedef struct packed {
        logic [15:0] term_count;
        logic [23:0] term_weight;
        logic        last_term;
    } term_t;

    typedef struct packed {
        logic [23:0] weighted_value;
        logic        last_result;
        logic [1:0]  row_status;
    } weighted_t;

    logic clk;
    logic rst_n;
    int   pending;
    int   failures;
    int   cycles;
    int   items_sent;
    bit   quiet;
    bit   hold_req;

    tfidf_if #(.payload_t(logic [15:0])) cfg_ch ();
    tfidf_if #(.payload_t(term_t))       in_ch ();
    tfidf_if #(.payload_t(weighted_t))   out_ch ();

    tfidf_row_weighting #(.MAX_TERMS(MaxTerms)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    tfidf_row_checker #(.MAX_TERMS(MaxTerms)) scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_ch.valid),
        .cfg_ready (cfg_ch.ready),
        .cfg_data  (cfg_ch.payload),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_data   (in_ch.payload),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.payload),
        .pending   (pending),
        .failures  (failures)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("tfidf_row_weighting_tb: errors");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (700) @(posedge clk);
                hold_req = 0;
            end
            else
                out_ch.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 21);
        end
    end

    task automatic send_term(input logic [15:0] count, input logic [23:0] weight,
                             input logic last);
        int gap;
        term_t t;
        gap = 0;
        if (!quiet)
            while ($urandom_range(0, 99) < 21)
                gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        t.term_count = count;
        t.term_weight = weight;
        t.last_term = last;
        in_ch.valid <= 1'b1;
        in_ch.payload <= t;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
    endtask

    // drain, let the block settle, then write the register
    task automatic set_smoothing(input logic [15:0] value);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SettleWait) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_count();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 3));
            1: return 16'($urandom_range(0, 255));
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_row(input int len);
        for (int k = 0; k < len; k++)
            send_term(pick_count(), 24'($urandom()), k == len - 1);
    endtask

    initial
    begin
        int len;
        cycles = 0;
        items_sent = 0;
        quiet = 0;
        hold_req = 0;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero denominator with reset smoothing, then directed rows at other smoothing settings
        send_term(16'd0, 24'hFFFFFF, 1'b1);
        send_term(16'd0, 24'h000001, 1'b0);
        send_term(16'd0, 24'h123456, 1'b1);
        send_term(16'd5, 24'h010000, 1'b0);
        send_term(16'd0, 24'h000000, 1'b1);
        set_smoothing(16'd0);
        send_term(16'hFFFF, 24'hFFFFFF, 1'b1);
        set_smoothing(16'hFFFF);
        send_term(16'hFFFF, 24'hFFFFFF, 1'b0);
        send_term(16'd0, 24'h000000, 1'b0);
        send_term(16'd1, 24'hFFFFFF, 1'b1);
        send_term(16'd0, 24'h800000, 1'b1);
        set_smoothing(16'h0100);
        send_term(16'hFFFF, 24'h7FFFFF, 1'b0);
        send_term(16'h8000, 24'hAAAAAA, 1'b0);
        send_term(16'h5555, 24'h555555, 1'b1);

        // long hold-off on results while further terms wait to be taken
        hold_req = 1;
        send_row(30);
        send_row(4);

        // overflowing row: 64 buffered, the rest dropped
        set_smoothing(16'd1);
        send_row(MaxTerms + 3);

        // stretch with no idling on either side
        quiet = 1;
        set_smoothing(16'($urandom()));
        for (int r = 0; r < 8; r++)
            send_row($urandom_range(1, 4));
        quiet = 0;

        while (items_sent < 270)
        begin
            if ($urandom_range(0, 9) == 0)
                set_smoothing($urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 3)));
            case ($urandom_range(0, 19))
                0: len = MaxTerms + $urandom_range(1, 3);
                1: len = MaxTerms;
                default: len = $urandom_range(1, 8);
            endcase
            send_row(len);
        end
        set_smoothing(16'hFFFF);
        send_row(3);

        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SettleWait) @(posedge clk);
        if (failures == 0)
            $display("tfidf_row_weighting_tb: clean");
        else
            $display("tfidf_row_weighting_tb: errors");
        $finish;
    end
endmodule
